>>> sv/lmlt_pkg.sv
// Shared types and constants for the LCD mode and scanline timing block.
`timescale 1ns / 1ps

package lmlt_pkg;

    // LCD mode codes as reported in the timing result.
    typedef enum logic [1:0] {
        LCD_HBLANK = 2'd0,
        LCD_VBLANK = 2'd1,
        LCD_OAM    = 2'd2,
        LCD_VRAM   = 2'd3
    } t_lcd_mode;

    // Bit positions inside the irq_en field of t_cfg.
    localparam int unsigned IRQ_EN_HBLANK = 0;
    localparam int unsigned IRQ_EN_VBLANK = 1;
    localparam int unsigned IRQ_EN_OAM    = 2;
    localparam int unsigned IRQ_EN_LYC    = 3;

    // Register indexes (word address bit 2 of the APB port).
    localparam logic REG_LINE_COMPARE = 1'b0;
    localparam logic REG_IRQ_ENABLES  = 1'b1;

    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;

    localparam logic [15:0] CYCLE_MAX = 16'hFFFF;

    typedef struct packed {
        logic [7:0] line_compare;
        logic [3:0] irq_en;
    } t_cfg;

    typedef struct packed {
        logic [5:0] elapsed_cycles;
        logic       line_done;
    } t_tick_req;

    typedef struct packed {
        t_lcd_mode   lcd_mode;
        logic [7:0]  line_number;
        logic        coincidence;
        logic        vblank_irq;
        logic        status_irq;
        logic [15:0] frame_count;
    } t_tick_rsp;

endpackage

>>> sv/lmlt_if.sv
// Valid/ready stream interfaces for tick requests and timing results.
`timescale 1ns / 1ps

interface lmlt_tick_if;
    logic       valid;
    logic       ready;
    logic [5:0] elapsed_cycles;
    logic       line_done;

    modport source (output valid, output elapsed_cycles, output line_done, input ready);
    modport sink   (input valid, input elapsed_cycles, input line_done, output ready);
endinterface

interface lmlt_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  lcd_mode;
    logic [7:0]  line_number;
    logic        coincidence;
    logic        vblank_irq;
    logic        status_irq;
    logic [15:0] frame_count;

    modport source (
        output valid, output lcd_mode, output line_number, output coincidence,
        output vblank_irq, output status_irq, output frame_count, input ready
    );
    modport sink (
        input valid, input lcd_mode, input line_number, input coincidence,
        input vblank_irq, input status_irq, input frame_count, output ready
    );
endinterface

>>> sv/lmlt_apb_regs.sv
// APB register file: line compare and status interrupt enables.
`timescale 1ns / 1ps

module lmlt_apb_regs
    import lmlt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic [APB_ADDR_W-1:0] i_paddr,
    input  logic [APB_DATA_W-1:0] i_pwdata,
    output logic [APB_DATA_W-1:0] o_prdata,
    output logic                  o_pready,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;
    logic wr_en;

    assign o_pready = 1'b1;
    assign wr_en    = i_psel && i_penable && i_pwrite;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (i_paddr[2])
                REG_LINE_COMPARE: n_cfg.line_compare = i_pwdata[7:0];
                REG_IRQ_ENABLES:  n_cfg.irq_en       = i_pwdata[3:0];
                default:          n_cfg              = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        case (i_paddr[2])
            REG_LINE_COMPARE: o_prdata = {24'd0, r_cfg.line_compare};
            REG_IRQ_ENABLES:  o_prdata = {28'd0, r_cfg.irq_en};
            default:          o_prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

>>> sv/lmlt_line_core.sv
// Mode sequencer, cycle counter, line counter and frame counter.
`timescale 1ns / 1ps

module lmlt_line_core
    import lmlt_pkg::*;
#(
    parameter int OAM_CYCLES         = 80,
    parameter int HBLANK_CYCLES      = 204,
    parameter int VBLANK_LINE_CYCLES = 456,
    parameter int VISIBLE_LINES      = 144,
    parameter int TOTAL_LINES        = 154
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step,
    input  t_tick_req i_req,
    input  t_cfg      i_cfg,
    output t_tick_rsp o_rsp
);

    t_lcd_mode   r_mode,  n_mode;
    logic [15:0] r_cyc,   n_cyc;
    logic [7:0]  r_line,  n_line;
    logic        r_coin,  n_coin;
    logic [15:0] r_frame, n_frame;
    logic        n_vbl;
    logic        n_stat;

    logic [16:0] cyc_sum;
    logic [15:0] cyc_sat;
    logic [7:0]  line_inc;
    logic        lyc_hit;
    logic        oam_end, hb_end, vbl_end;
    logic        to_vblank, frame_end;

    // Saturating cycle accumulate and the end-of-period compares.
    always_comb begin
        cyc_sum   = {1'b0, r_cyc} + {11'd0, i_req.elapsed_cycles};
        cyc_sat   = cyc_sum[16] ? CYCLE_MAX : cyc_sum[15:0];
        line_inc  = r_line + 8'd1;
        lyc_hit   = (line_inc == i_cfg.line_compare);
        oam_end   = (cyc_sat >= 16'(OAM_CYCLES));
        hb_end    = (cyc_sat >= 16'(HBLANK_CYCLES));
        vbl_end   = (cyc_sat >= 16'(VBLANK_LINE_CYCLES));
        to_vblank = (line_inc >= 8'(VISIBLE_LINES));
        frame_end = (line_inc >= 8'(TOTAL_LINES));
    end

    // Next mode.
    always_comb begin
        n_mode = r_mode;
        case (r_mode)
            LCD_OAM:    if (oam_end) n_mode = LCD_VRAM;
            LCD_VRAM:   if (i_req.line_done) n_mode = LCD_HBLANK;
            LCD_HBLANK: if (hb_end) n_mode = to_vblank ? LCD_VBLANK : LCD_OAM;
            LCD_VBLANK: if (vbl_end && frame_end) n_mode = LCD_OAM;
            default:    n_mode = r_mode;
        endcase
    end

    // Counters, compare flag and interrupt requests.
    always_comb begin
        n_cyc   = cyc_sat;
        n_line  = r_line;
        n_coin  = r_coin;
        n_frame = r_frame;
        n_vbl   = 1'b0;
        n_stat  = 1'b0;
        case (r_mode)
            LCD_OAM: begin
                if (oam_end) n_cyc = '0;
            end
            LCD_VRAM: begin
                if (i_req.line_done) n_stat = i_cfg.irq_en[IRQ_EN_HBLANK];
            end
            LCD_HBLANK: begin
                if (hb_end) begin
                    n_cyc  = '0;
                    n_line = line_inc;
                    n_coin = lyc_hit;
                    if (to_vblank) begin
                        n_vbl   = 1'b1;
                        n_frame = r_frame + 16'd1;
                        n_stat  = (lyc_hit && i_cfg.irq_en[IRQ_EN_LYC])
                                  || i_cfg.irq_en[IRQ_EN_VBLANK];
                    end else begin
                        n_stat  = (lyc_hit && i_cfg.irq_en[IRQ_EN_LYC])
                                  || i_cfg.irq_en[IRQ_EN_OAM];
                    end
                end
            end
            LCD_VBLANK: begin
                if (vbl_end) begin
                    n_cyc  = '0;
                    n_coin = lyc_hit;
                    n_stat = lyc_hit && i_cfg.irq_en[IRQ_EN_LYC];
                    if (frame_end) begin
                        n_line = '0;
                        n_stat = n_stat || i_cfg.irq_en[IRQ_EN_OAM];
                    end else begin
                        n_line = line_inc;
                    end
                end
            end
            default: begin
                n_cyc = cyc_sat;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= LCD_OAM;
            r_cyc   <= '0;
            r_line  <= '0;
            r_coin  <= 1'b0;
            r_frame <= '0;
        end else if (i_step) begin
            r_mode  <= n_mode;
            r_cyc   <= n_cyc;
            r_line  <= n_line;
            r_coin  <= n_coin;
            r_frame <= n_frame;
        end
    end

    assign o_rsp.lcd_mode    = n_mode;
    assign o_rsp.line_number = n_line;
    assign o_rsp.coincidence = n_coin;
    assign o_rsp.vblank_irq  = n_vbl;
    assign o_rsp.status_irq  = n_stat;
    assign o_rsp.frame_count = n_frame;

`ifndef ASSERT_OFF
    a_vblank_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == LCD_VBLANK |-> r_line >= 8'(VISIBLE_LINES))
        else $error("vblank mode on a visible line");

    a_visible_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode != LCD_VBLANK |-> r_line < 8'(VISIBLE_LINES))
        else $error("visible mode outside the visible lines");

    a_frame_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_frame != $past(r_frame))
        |-> (r_mode == LCD_VBLANK && $past(r_mode) == LCD_HBLANK))
        else $error("frame count moved outside the entry to vblank");

    a_oam_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(r_mode) == LCD_OAM && r_mode == LCD_VRAM)
        |-> r_cyc == '0)
        else $error("cycle count not cleared at the end of oam");
`endif

endmodule

>>> sv/lcd_mode_line_timing.sv
// Top level of the LCD mode and scanline timing block.
`timescale 1ns / 1ps

// LCD mode and scanline timing. Each tick request adds elapsed machine
// cycles to a saturating 16-bit count and steps the mode sequence
// OAM -> VRAM -> HBLANK -> OAM ... and, after the last visible line, VBLANK.
// One result comes back per request with the mode, line counter, compare
// flag, vblank / status interrupt requests and the frame count. Throughput
// is one request per clock while the sink is ready. A request passes the
// input register, then the mode/counter update and result register. The
// only feedback loop is the state update, so back-to-back requests run at
// full rate. The output register is loaded only when it is empty or being
// drained, so a stalled sink holds the result and the input register
// absorbs one more request before the tick channel is backpressured.
// Config (APB, addr 0x0 line compare, 0x4 interrupt enables) must be written
// while no request is in flight; a new compare value applies from the next
// line increment onward.
module lcd_mode_line_timing
    import lmlt_pkg::*;
#(
    parameter int OAM_CYCLES         = 80,
    parameter int HBLANK_CYCLES      = 204,
    parameter int VBLANK_LINE_CYCLES = 456,
    parameter int VISIBLE_LINES      = 144,
    parameter int TOTAL_LINES        = 154
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    lmlt_tick_if.sink             i_tick,
    lmlt_result_if.source         o_result,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic [APB_ADDR_W-1:0] i_paddr,
    input  logic [APB_DATA_W-1:0] i_pwdata,
    output logic [APB_DATA_W-1:0] o_prdata,
    output logic                  o_pready
);

    t_cfg      cfg;
    t_tick_rsp core_rsp;

    logic      r_in_valid, n_in_valid;
    t_tick_req r_in_req;
    logic      r_out_valid, n_out_valid;
    t_tick_rsp r_out_rsp;

    logic in_acc;   // tick request taken this cycle
    logic advance;  // result register free to load
    logic step;     // buffered request processed this cycle

    lmlt_apb_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready),
        .o_cfg     (cfg)
    );

    lmlt_line_core #(
        .OAM_CYCLES         (OAM_CYCLES),
        .HBLANK_CYCLES      (HBLANK_CYCLES),
        .VBLANK_LINE_CYCLES (VBLANK_LINE_CYCLES),
        .VISIBLE_LINES      (VISIBLE_LINES),
        .TOTAL_LINES        (TOTAL_LINES)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_req   (r_in_req),
        .i_cfg   (cfg),
        .o_rsp   (core_rsp)
    );

    // Handshake: the input stage drains whenever the result stage can load.
    assign advance      = !r_out_valid || o_result.ready;
    assign step         = r_in_valid && advance;
    assign i_tick.ready = !r_in_valid || advance;
    assign in_acc       = i_tick.valid && i_tick.ready;

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_acc) begin
            n_in_valid = 1'b1;
        end else if (advance) begin
            n_in_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (step) begin
            n_out_valid = 1'b1;
        end else if (o_result.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers, no reset needed.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_req.elapsed_cycles <= i_tick.elapsed_cycles;
            r_in_req.line_done      <= i_tick.line_done;
        end
        if (step) begin
            r_out_rsp <= core_rsp;
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.lcd_mode    = r_out_rsp.lcd_mode;
    assign o_result.line_number = r_out_rsp.line_number;
    assign o_result.coincidence = r_out_rsp.coincidence;
    assign o_result.vblank_irq  = r_out_rsp.vblank_irq;
    assign o_result.status_irq  = r_out_rsp.status_irq;
    assign o_result.frame_count = r_out_rsp.frame_count;

`ifndef ASSERT_OFF
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |-> !i_tick.ready)
        else $error("tick request taken over a buffered one");

    a_step_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> r_out_valid)
        else $error("processed request produced no result");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_result.ready) |=> (r_out_valid && $stable(r_out_rsp)))
        else $error("stalled result changed");
`endif

endmodule
